// ===== hdl/plg_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plg_pkg
// Shared codes, types and heading tables for the maze walker.
// ----------------------------------------------------------------------------
package plg_pkg;

  // request operation codes
  localparam logic [1:0] OP_VWALL = 2'd0;
  localparam logic [1:0] OP_HWALL = 2'd1;
  localparam logic [1:0] OP_START = 2'd2;
  localparam logic [1:0] OP_STEP  = 2'd3;

  // headings
  localparam logic [1:0] H_NORTH = 2'd0;
  localparam logic [1:0] H_SOUTH = 2'd1;
  localparam logic [1:0] H_WEST  = 2'd2;
  localparam logic [1:0] H_EAST  = 2'd3;

  // move modes
  localparam logic [1:0] M_FIRST  = 2'd0;
  localparam logic [1:0] M_RUN    = 2'd1;
  localparam logic [1:0] M_FOLLOW = 2'd2;

  // configuration register indexes
  localparam logic [2:0] CFG_START_ROW = 3'd0;
  localparam logic [2:0] CFG_START_COL = 3'd1;
  localparam logic [2:0] CFG_GOAL_ROW  = 3'd2;
  localparam logic [2:0] CFG_GOAL_COL  = 3'd3;
  localparam logic [2:0] CFG_MAZE_ROWS = 3'd4;
  localparam logic [2:0] CFG_MAZE_COLS = 3'd5;

  typedef logic [1:0] head_t;

  // controller to datapath
  typedef struct packed {
    logic       ld_in;     // latch request fields
    logic       wr_wall;   // write latched wall bit
    logic       init;      // place robot on entrance
    logic       move;      // take the candidate move
    logic [1:0] mode;
    logic [1:0] cidx;      // candidate number
  } plg_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic [1:0] op;
    logic       at_goal;
    logic       turns_zero;
    logic       move_ok;
  } plg_sts_t;

  function automatic head_t right_of(input head_t d);
    case (d)
      H_NORTH: right_of = H_EAST;
      H_SOUTH: right_of = H_WEST;
      H_WEST:  right_of = H_NORTH;
      default: right_of = H_SOUTH;
    endcase
  endfunction

  function automatic head_t left_of(input head_t d);
    case (d)
      H_NORTH: left_of = H_WEST;
      H_SOUTH: left_of = H_EAST;
      H_WEST:  left_of = H_SOUTH;
      default: left_of = H_NORTH;
    endcase
  endfunction

  // first move order: east, south, west, north
  function automatic head_t first_dir(input logic [1:0] i);
    case (i)
      2'd0:    first_dir = H_EAST;
      2'd1:    first_dir = H_SOUTH;
      2'd2:    first_dir = H_WEST;
      default: first_dir = H_NORTH;
    endcase
  endfunction

  // wall-follow order: right, straight, left, back
  function automatic head_t follow_dir(input head_t d, input logic [1:0] i);
    case (i)
      2'd0:    follow_dir = right_of(d);
      2'd1:    follow_dir = d;
      2'd2:    follow_dir = left_of(d);
      default: follow_dir = d ^ 2'd1;
    endcase
  endfunction

endpackage

// ===== hdl/plg_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plg_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module plg_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 272
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hdl/plg_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plg_ctrl
// Sequencer: dispatches requests, runs the straight run and candidate moves.
// ----------------------------------------------------------------------------
module plg_ctrl
  import plg_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  output logic     busy,
  input  plg_sts_t sts,
  output plg_cmd_t cmd,
  output logic     out_valid,
  output logic     out_last
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_DISP = 2'd1;
  localparam logic [1:0] S_RD   = 2'd2;
  localparam logic [1:0] S_EV   = 2'd3;

  logic [1:0] state_r, state_nxt;
  logic [1:0] mode_r, mode_nxt;
  logic [1:0] cidx_r, cidx_nxt;
  logic       val_r, val_nxt;
  logic       last_r, last_nxt;

  assign busy      = (state_r != S_IDLE);
  assign out_valid = val_r;
  assign out_last  = last_r;

  // next state and commands
  always_comb begin
    state_nxt   = state_r;
    mode_nxt    = mode_r;
    cidx_nxt    = cidx_r;
    val_nxt     = 1'b0;
    last_nxt    = last_r;
    cmd         = '0;
    cmd.mode    = mode_r;
    cmd.cidx    = cidx_r;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.ld_in = 1'b1;
          state_nxt = S_DISP;
        end
      end
      S_DISP: begin
        case (sts.op)
          OP_VWALL, OP_HWALL: begin
            cmd.wr_wall = 1'b1;
            state_nxt   = S_IDLE;
          end
          OP_START: begin
            cmd.init  = 1'b1;
            mode_nxt  = M_FIRST;
            cidx_nxt  = 2'd0;
            state_nxt = S_RD;
          end
          default: begin
            if (sts.at_goal) begin
              val_nxt   = 1'b1;
              last_nxt  = 1'b1;
              state_nxt = S_IDLE;
            end else begin
              mode_nxt  = sts.turns_zero ? M_RUN : M_FOLLOW;
              cidx_nxt  = 2'd0;
              state_nxt = S_RD;
            end
          end
        endcase
      end
      S_RD: begin
        state_nxt = S_EV;
      end
      default: begin
        if (mode_r == M_RUN) begin
          if (sts.move_ok) begin
            cmd.move  = 1'b1;
            state_nxt = S_RD;
          end else begin
            // run blocked: report, then follow the wall
            val_nxt   = 1'b1;
            last_nxt  = 1'b0;
            mode_nxt  = M_FOLLOW;
            cidx_nxt  = 2'd0;
            state_nxt = S_RD;
          end
        end else if (sts.move_ok || cidx_r == 2'd3) begin
          cmd.move  = sts.move_ok;
          val_nxt   = 1'b1;
          last_nxt  = 1'b1;
          state_nxt = S_IDLE;
        end else begin
          cidx_nxt  = cidx_r + 2'd1;
          state_nxt = S_RD;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      mode_r  <= M_FIRST;
      cidx_r  <= 2'd0;
      val_r   <= 1'b0;
      last_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      mode_r  <= mode_nxt;
      cidx_r  <= cidx_nxt;
      val_r   <= val_nxt;
      last_r  <= last_nxt;
    end
  end

endmodule

// ===== hdl/plg_dp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plg_dp
// Datapath: config registers, wall stores, robot position, heading, count.
// ----------------------------------------------------------------------------
module plg_dp
  import plg_pkg::*;
#(
  parameter int MAX_ROWS    = 16,
  parameter int MAX_COLS    = 16,
  parameter int COUNT_WIDTH = 8
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_we,
  input  logic [2:0] cfg_index,
  input  logic [4:0] cfg_data,
  input  logic [1:0] in_op,
  input  logic [4:0] in_wall_row,
  input  logic [4:0] in_wall_col,
  input  logic       in_wall_present,
  input  plg_cmd_t   cmd,
  output plg_sts_t   sts,
  output logic [3:0] robot_row,
  output logic [3:0] robot_col,
  output logic [1:0] heading,
  output logic [7:0] turn_count,
  output logic       at_goal
);

  localparam int VDEPTH = MAX_ROWS * (MAX_COLS + 1);
  localparam int HDEPTH = (MAX_ROWS + 1) * MAX_COLS;
  localparam int VAW    = $clog2(VDEPTH);
  localparam int HAW    = $clog2(HDEPTH);
  localparam int CW     = COUNT_WIDTH;
  localparam int TW     = COUNT_WIDTH + 2;
  localparam logic signed [TW-1:0] LIMIT = TW'((1 << (CW - 1)) - 1);

  // configuration registers
  logic [3:0] start_row_r, start_col_r, goal_row_r, goal_col_r;
  logic [4:0] maze_rows_r, maze_cols_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_row_r <= 4'd0;
      start_col_r <= 4'd0;
      goal_row_r  <= 4'd4;
      goal_col_r  <= 4'd1;
      maze_rows_r <= 5'd16;
      maze_cols_r <= 5'd16;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_START_ROW: start_row_r <= cfg_data[3:0];
        CFG_START_COL: start_col_r <= cfg_data[3:0];
        CFG_GOAL_ROW:  goal_row_r  <= cfg_data[3:0];
        CFG_GOAL_COL:  goal_col_r  <= cfg_data[3:0];
        CFG_MAZE_ROWS: maze_rows_r <= cfg_data;
        CFG_MAZE_COLS: maze_cols_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // latched request
  logic [1:0] op_r;
  logic [4:0] wrow_r, wcol_r;
  logic       wpres_r;

  always_ff @(posedge clk) begin
    if (cmd.ld_in) begin
      op_r    <= in_op;
      wrow_r  <= in_wall_row;
      wcol_r  <= in_wall_col;
      wpres_r <= in_wall_present;
    end
  end

  // robot state
  logic [3:0]           row_r, col_r;
  logic [1:0]           dir_r;
  logic signed [CW-1:0] turns_r;

  // candidate heading for this try
  head_t try_dir;
  always_comb begin
    case (cmd.mode)
      M_FIRST: try_dir = first_dir(cmd.cidx);
      M_RUN:   try_dir = dir_r;
      default: try_dir = follow_dir(dir_r, cmd.cidx);
    endcase
  end

  // neighbour cell and wall address
  logic [8:0] r9, c9, nr, nc, wr9, wc9, er, ec;
  logic       edge_ok, is_h, inrange;
  always_comb begin
    r9      = {5'd0, row_r};
    c9      = {5'd0, col_r};
    nr      = r9;
    nc      = c9;
    wr9     = r9;
    wc9     = c9;
    edge_ok = 1'b1;
    is_h    = 1'b0;
    case (try_dir)
      H_NORTH: begin
        edge_ok = (row_r != 4'd0);
        nr      = r9 - 9'd1;
        is_h    = 1'b1;
      end
      H_SOUTH: begin
        nr   = r9 + 9'd1;
        wr9  = r9 + 9'd1;
        is_h = 1'b1;
      end
      H_WEST: begin
        edge_ok = (col_r != 4'd0);
        nc      = c9 - 9'd1;
      end
      default: begin
        nc  = c9 + 9'd1;
        wc9 = c9 + 9'd1;
      end
    endcase
    if (is_h) begin
      inrange = (32'(wr9) <= MAX_ROWS) && (32'(wc9) < MAX_COLS);
    end else begin
      inrange = (32'(wr9) < MAX_ROWS) && (32'(wc9) <= MAX_COLS);
    end
    er = (32'(maze_rows_r) < MAX_ROWS) ? {4'd0, maze_rows_r} : 9'(MAX_ROWS);
    ec = (32'(maze_cols_r) < MAX_COLS) ? {4'd0, maze_cols_r} : 9'(MAX_COLS);
  end

  // wall stores
  logic [VAW-1:0] v_raddr, v_waddr;
  logic [HAW-1:0] h_raddr, h_waddr;
  logic           v_we, h_we, v_bit, h_bit;
  logic           inrange_r, is_h_r;

  assign v_raddr = VAW'(32'(wr9) * (MAX_COLS + 1) + 32'(wc9));
  assign h_raddr = HAW'(32'(wr9) * MAX_COLS + 32'(wc9));
  assign v_waddr = VAW'(32'(wrow_r) * (MAX_COLS + 1) + 32'(wcol_r));
  assign h_waddr = HAW'(32'(wrow_r) * MAX_COLS + 32'(wcol_r));
  assign v_we    = cmd.wr_wall && (op_r == OP_VWALL)
                   && (32'(wrow_r) < MAX_ROWS) && (32'(wcol_r) <= MAX_COLS);
  assign h_we    = cmd.wr_wall && (op_r == OP_HWALL)
                   && (32'(wrow_r) <= MAX_ROWS) && (32'(wcol_r) < MAX_COLS);

  plg_ram #(.WIDTH(1), .DEPTH(VDEPTH)) u_vram (
    .clk   (clk),
    .we    (v_we),
    .waddr (v_waddr),
    .wdata (wpres_r),
    .raddr (v_raddr),
    .rdata (v_bit)
  );

  plg_ram #(.WIDTH(1), .DEPTH(HDEPTH)) u_hram (
    .clk   (clk),
    .we    (h_we),
    .waddr (h_waddr),
    .wdata (wpres_r),
    .raddr (h_raddr),
    .rdata (h_bit)
  );

  // range flag is registered alongside the wall store read data
  always_ff @(posedge clk) begin
    inrange_r <= inrange;
    is_h_r    <= is_h;
  end

  // move test
  logic wall;
  assign wall = !inrange_r || (is_h_r ? h_bit : v_bit);

  always_comb begin
    sts.op         = op_r;
    sts.at_goal    = at_goal;
    sts.turns_zero = (turns_r == '0);
    sts.move_ok    = edge_ok && !wall && (nr < er) && (nc < ec)
                     && !((nr == {5'd0, start_row_r}) && (nc == {5'd0, start_col_r}));
  end

  // saturating turn update: delta is candidate number minus one
  logic signed [TW-1:0] tsum, tsat;
  always_comb begin
    tsum = TW'(turns_r) + TW'(signed'({1'b0, cmd.cidx})) - TW'(1);
    if (tsum > LIMIT) begin
      tsat = LIMIT;
    end else if (tsum < -LIMIT) begin
      tsat = -LIMIT;
    end else begin
      tsat = tsum;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r   <= 4'd0;
      col_r   <= 4'd0;
      dir_r   <= H_NORTH;
      turns_r <= '0;
    end else if (cmd.init) begin
      row_r   <= start_row_r;
      col_r   <= start_col_r;
      dir_r   <= H_NORTH;
      turns_r <= '0;
    end else if (cmd.move) begin
      row_r <= nr[3:0];
      col_r <= nc[3:0];
      if (cmd.mode != M_RUN) begin
        dir_r <= try_dir;
      end
      if (cmd.mode == M_FOLLOW) begin
        turns_r <= CW'(tsat);
      end
    end
  end

  // result fields
  assign robot_row  = row_r;
  assign robot_col  = col_r;
  assign heading    = dir_r;
  assign turn_count = 8'(turns_r);
  assign at_goal    = (row_r == goal_row_r) && (col_r == goal_col_r);

endmodule

// ===== hdl/pledge_maze_walker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pledge_maze_walker
// Grid maze walker with a Pledge-style wall-follow rule.
// ----------------------------------------------------------------------------
// Usage:
//   Requests are accepted when start is high and busy is low. Wall writes
//   (op 0/1) load one bit of the vertical or horizontal store; start (op 2)
//   puts the robot on the entrance and makes its first move; step (op 3)
//   makes a straight run when the turn count is zero, then one wall-follow
//   move. Results appear on out_* for one cycle with out_valid high;
//   out_last marks the final result of a request. Results cannot be stalled.
//   Each move try is a wall read state then an evaluate state, set by the
//   registered wall store read. busy stays high until the last result.
//   Config writes (cfg_valid/cfg_ready, always ready) must go in while
//   idle; the block itself does not enforce this. Reset clears position,
//   heading and count and loads the config defaults; the wall stores are
//   not cleared and must be written before use.
// ----------------------------------------------------------------------------
module pledge_maze_walker
  import plg_pkg::*;
#(
  parameter int MAX_ROWS    = 16,
  parameter int MAX_COLS    = 16,
  parameter int COUNT_WIDTH = 8
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  output logic       busy,
  input  logic [1:0] in_op,
  input  logic [4:0] in_wall_row,
  input  logic [4:0] in_wall_col,
  input  logic       in_wall_present,
  output logic       out_valid,
  output logic [3:0] out_robot_row,
  output logic [3:0] out_robot_col,
  output logic [1:0] out_heading,
  output logic [7:0] out_turn_count,
  output logic       out_at_goal,
  output logic       out_last,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [2:0] cfg_index,
  input  logic [4:0] cfg_data
);

  plg_cmd_t cmd;
  plg_sts_t sts;

  assign cfg_ready = 1'b1;

  plg_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .sts       (sts),
    .cmd       (cmd),
    .out_valid (out_valid),
    .out_last  (out_last)
  );

  plg_dp #(
    .MAX_ROWS    (MAX_ROWS),
    .MAX_COLS    (MAX_COLS),
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_valid && cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .in_op           (in_op),
    .in_wall_row     (in_wall_row),
    .in_wall_col     (in_wall_col),
    .in_wall_present (in_wall_present),
    .cmd             (cmd),
    .sts             (sts),
    .robot_row       (out_robot_row),
    .robot_col       (out_robot_col),
    .heading         (out_heading),
    .turn_count      (out_turn_count),
    .at_goal         (out_at_goal)
  );

`ifndef SYNTHESIS
  // accepted request keeps the block busy next cycle
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy) else $error("request accepted but not busy");

  // a non-final result is followed by more work
  a_run_more: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_last) |-> busy) else $error("run result without follow move");

  // a move never changes state while idle
  a_idle_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (!busy && !$past(busy) && $past(rst_n)) |-> $stable(out_robot_row))
    else $error("position changed while idle");
`endif

endmodule

// ===== test/pledge_maze_walker_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pledge_maze_walker_tb
// Self-checking bench for the maze walker: loads the whole wall store, runs a
// short table of hand-picked requests, then closed corridors and loops that
// drive the turn count into both saturation limits, then random mazes under
// several entrance, goal and size settings. Every result is compared with a
// behavioural model of the walker held in the bench, or with a table row's typed results.
// ----------------------------------------------------------------------------
module pledge_maze_walker_tb;
  import plg_pkg::*;

  localparam int NR = 16;
  localparam int NC = 16;
  localparam int TURN_MAX = 127;
  localparam int DRAIN_CYCLES = 60;
  localparam int CYCLE_LIMIT = 600000;

  typedef struct packed {
    logic [3:0] row;
    logic [3:0] col;
    logic [1:0] hd;
    logic [7:0] tc;
    logic       goal;
    logic       last;
  } walk_res_t;

  typedef struct {
    logic [1:0] op;
    logic [4:0] wr;
    logic [4:0] wc;
    logic       wp;
    int         n_typed;
    walk_res_t  r0;
    walk_res_t  r1;
  } stim_row_t;

  logic clk, rst_n;
  logic start, busy;
  logic [1:0] in_op;
  logic [4:0] in_wall_row, in_wall_col;
  logic in_wall_present;
  logic out_valid;
  logic [3:0] out_robot_row, out_robot_col;
  logic [1:0] out_heading;
  logic [7:0] out_turn_count;
  logic out_at_goal, out_last;
  logic cfg_valid, cfg_ready;
  logic [2:0] cfg_index;
  logic [4:0] cfg_data;

  pledge_maze_walker dut (.*);

  // walker state mirrored in the bench
  bit vw [NR*(NC+1)];
  bit hw [(NR+1)*NC];
  int s_row, s_col, g_row, g_col, m_rows, m_cols;
  int p_row, p_col, p_dir, p_turns;

  walk_res_t pending_q[$];
  int errors, n_items, n_results, n_goal, n_sat_pos, n_sat_neg, cycles;
  bit no_idle;

  initial begin
    clk = 0;
    forever #4 clk = ~clk;
  end

  // ---- behavioural model --------------------------------------------------
  function automatic bit vwall_at(int r, int c);
    if (r >= NR || c > NC) return 1;
    return vw[r*(NC+1)+c];
  endfunction

  function automatic bit hwall_at(int r, int c);
    if (r > NR || c >= NC) return 1;
    return hw[r*NC+c];
  endfunction

  function automatic bit try_move(int d);
    int er, ec, nr, nc;
    bit wall;
    er = (m_rows < NR) ? m_rows : NR;
    ec = (m_cols < NC) ? m_cols : NC;
    nr = p_row;
    nc = p_col;
    case (d[1:0])
      H_NORTH: begin
        if (p_row == 0) return 0;
        nr = p_row - 1; wall = hwall_at(p_row, p_col);
      end
      H_SOUTH: begin
        nr = p_row + 1; wall = hwall_at(p_row + 1, p_col);
      end
      H_WEST: begin
        if (p_col == 0) return 0;
        nc = p_col - 1; wall = vwall_at(p_row, p_col);
      end
      default: begin
        nc = p_col + 1; wall = vwall_at(p_row, p_col + 1);
      end
    endcase
    if (wall || nr >= er || nc >= ec) return 0;
    if (nr == s_row && nc == s_col) return 0;
    p_row = nr;
    p_col = nc;
    return 1;
  endfunction

  function automatic walk_res_t snapshot(bit lst);
    walk_res_t r;
    r.row  = p_row[3:0];
    r.col  = p_col[3:0];
    r.hd   = p_dir[1:0];
    r.tc   = p_turns[7:0];
    r.goal = (p_row == g_row && p_col == g_col);
    r.last = lst;
    return r;
  endfunction

  // applies one request to the model and returns the results it causes
  task automatic walk_request(input logic [1:0] op, input int wr, input int wc,
                              input bit wp, output walk_res_t res[$]);
    head_t cand [4];
    int dt [4] = '{-1, 0, 1, 2};
    head_t d;
    res = {};
    case (op)
      OP_VWALL: if (wr < NR && wc <= NC) vw[wr*(NC+1)+wc] = wp;
      OP_HWALL: if (wr <= NR && wc < NC) hw[wr*NC+wc] = wp;
      OP_START: begin
        p_row = s_row; p_col = s_col; p_dir = H_NORTH; p_turns = 0;
        if (try_move(H_EAST)) p_dir = H_EAST;
        else if (try_move(H_SOUTH)) p_dir = H_SOUTH;
        else if (try_move(H_WEST)) p_dir = H_WEST;
        else if (try_move(H_NORTH)) p_dir = H_NORTH;
        res.push_back(snapshot(1));
      end
      default: begin
        if (p_row == g_row && p_col == g_col) begin
          res.push_back(snapshot(1));
        end else begin
          if (p_turns == 0) begin
            while (try_move(p_dir)) ;
            res.push_back(snapshot(0));
          end
          d = p_dir[1:0];
          cand[0] = right_of(d) == d ? d : right_of(d);
          cand[1] = d;
          cand[2] = left_of(d);
          cand[3] = d ^ 2'd1;
          for (int i = 0; i < 4; i++) begin
            if (try_move(cand[i])) begin
              p_dir = cand[i];
              p_turns += dt[i];
              if (p_turns > TURN_MAX) p_turns = TURN_MAX;
              if (p_turns < -TURN_MAX) p_turns = -TURN_MAX;
              break;
            end
          end
          res.push_back(snapshot(1));
        end
      end
    endcase
  endtask

  // ---- request driver -----------------------------------------------------
  task automatic send(input logic [1:0] op, input int wr, input int wc, input bit wp,
                      input int n_typed = 0, input walk_res_t t0 = '0,
                      input walk_res_t t1 = '0);
    walk_res_t res[$];
    start <= 1'b1;
    in_op <= op;
    in_wall_row <= wr[4:0];
    in_wall_col <= wc[4:0];
    in_wall_present <= wp;
    do @(posedge clk); while (busy);
    walk_request(op, wr, wc, wp, res);
    if (n_typed > 0) begin
      res = {t0};
      if (n_typed > 1) res.push_back(t1);
    end
    foreach (res[i]) pending_q.push_back(res[i]);
    n_items++;
    if (!no_idle && $urandom_range(0, 99) < 20) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
  endtask

  // idle point: all results in, then enough cycles for a trailing write
  task automatic settle();
    start <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // valid stays high across a burst; set_maze drops it after the last write
  task automatic cfg_write(input logic [2:0] idx, input int val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val[4:0];
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_START_ROW: s_row = val & 15;
      CFG_START_COL: s_col = val & 15;
      CFG_GOAL_ROW:  g_row = val & 15;
      CFG_GOAL_COL:  g_col = val & 15;
      CFG_MAZE_ROWS: m_rows = val & 31;
      default:       m_cols = val & 31;
    endcase
  endtask

  task automatic set_maze(int sr, int sc, int gr, int gc, int rows, int cols);
    cfg_write(CFG_START_ROW, sr);
    cfg_write(CFG_START_COL, sc);
    cfg_write(CFG_GOAL_ROW, gr);
    cfg_write(CFG_GOAL_COL, gc);
    cfg_write(CFG_MAZE_ROWS, rows);
    cfg_write(CFG_MAZE_COLS, cols);
    cfg_valid <= 1'b0;
  endtask

  task automatic random_walk(int n);
    int sel;
    for (int i = 0; i < n; i++) begin
      sel = $urandom_range(0, 99);
      if (sel < 58) send(OP_STEP, $urandom_range(0, 31), $urandom_range(0, 31), $urandom_range(0, 1));
      else if (sel < 68) send(OP_START, $urandom_range(0, 31), $urandom_range(0, 31), $urandom_range(0, 1));
      else if (sel < 90)
        send(sel[0] ? OP_HWALL : OP_VWALL, $urandom_range(0, 16), $urandom_range(0, 16),
             $urandom_range(0, 99) < 35);
      else
        send(sel[0] ? OP_HWALL : OP_VWALL, $urandom_range(0, 31), $urandom_range(0, 31),
             $urandom_range(0, 1));
    end
  endtask

  // ---- result checker -----------------------------------------------------
  always @(posedge clk) begin
    walk_res_t e;
    if (rst_n && out_valid) begin
      n_results++;
      if (pending_q.size() == 0) begin
        $error("unexpected result row=%0d col=%0d", out_robot_row, out_robot_col);
        errors++;
      end else begin
        e = pending_q.pop_front();
        if (out_robot_row !== e.row) begin
          $error("robot_row exp %0d got %0d", e.row, out_robot_row); errors++;
        end
        if (out_robot_col !== e.col) begin
          $error("robot_col exp %0d got %0d", e.col, out_robot_col); errors++;
        end
        if (out_heading !== e.hd) begin
          $error("heading exp %0d got %0d", e.hd, out_heading); errors++;
        end
        if (out_turn_count !== e.tc) begin
          $error("turn_count exp %0d got %0d", $signed(e.tc), $signed(out_turn_count));
          errors++;
        end
        if (out_at_goal !== e.goal) begin
          $error("at_goal exp %0d got %0d", e.goal, out_at_goal); errors++;
        end
        if (out_last !== e.last) begin
          $error("last exp %0d got %0d", e.last, out_last); errors++;
        end
        if (e.goal) n_goal++;
        if ($signed(e.tc) == TURN_MAX) n_sat_pos++;
        if ($signed(e.tc) == -TURN_MAX) n_sat_neg++;
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("pledge_maze_walker test failed");
      $finish;
    end
  end

  // ---- stimulus -----------------------------------------------------------
  initial begin
    stim_row_t tbl [$];
    walk_res_t n0, n0_run;
    start = 0; in_op = OP_VWALL; in_wall_row = 0; in_wall_col = 0; in_wall_present = 0;
    cfg_valid = 0; cfg_index = CFG_START_ROW; cfg_data = 0;
    errors = 0; n_items = 0; n_results = 0; cycles = 0;
    n_goal = 0; n_sat_pos = 0; n_sat_neg = 0; no_idle = 0;
    s_row = 0; s_col = 0; g_row = 4; g_col = 1; m_rows = 16; m_cols = 16;
    p_row = 0; p_col = 0; p_dir = H_NORTH; p_turns = 0;
    rst_n = 0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // load every wall bit so no later walk reads an unwritten one
    for (int r = 0; r < NR; r++)
      for (int c = 0; c <= NC; c++) send(OP_VWALL, r, c, $urandom_range(0, 99) < 30);
    for (int r = 0; r <= NR; r++)
      for (int c = 0; c < NC; c++) send(OP_HWALL, r, c, $urandom_range(0, 99) < 30);

    // directed table: boxed-in entrance, out-of-store writes, store edges
    n0     = '{row: 0, col: 0, hd: H_NORTH, tc: 0, goal: 0, last: 1};
    n0_run = '{row: 0, col: 0, hd: H_NORTH, tc: 0, goal: 0, last: 0};
    tbl = '{
      '{OP_VWALL, 0, 1, 1, 0, '0, '0},
      '{OP_HWALL, 1, 0, 1, 0, '0, '0},
      '{OP_START, 31, 31, 1, 1, n0, '0},       // no move possible
      '{OP_STEP, 0, 0, 0, 2, n0_run, n0},      // run and follow both refused
      '{OP_VWALL, 31, 31, 1, 0, '0, '0},       // outside store, ignored
      '{OP_HWALL, 16, 16, 1, 0, '0, '0},       // outside store, ignored
      '{OP_VWALL, 16, 0, 1, 0, '0, '0},        // outside store, ignored
      '{OP_HWALL, 16, 15, 1, 0, '0, '0},
      '{OP_VWALL, 15, 16, 1, 0, '0, '0},
      '{OP_VWALL, 0, 1, 0, 0, '0, '0},
      '{OP_START, 0, 0, 0, 0, '0, '0},
      '{OP_STEP, 0, 0, 0, 0, '0, '0},
      '{OP_STEP, 31, 31, 1, 0, '0, '0},
      '{OP_STEP, 0, 0, 0, 0, '0, '0},
      '{OP_STEP, 0, 0, 0, 0, '0, '0},
      '{OP_START, 0, 0, 0, 0, '0, '0},
      '{OP_STEP, 0, 0, 0, 0, '0, '0}
    };
    foreach (tbl[i])
      send(tbl[i].op, tbl[i].wr, tbl[i].wc, tbl[i].wp, tbl[i].n_typed, tbl[i].r0, tbl[i].r1);
    settle();

    // one-row corridor: bouncing back each step drives the count to +127
    set_maze(0, 0, 15, 15, 1, 3);
    send(OP_VWALL, 0, 1, 0);
    send(OP_VWALL, 0, 2, 0);
    send(OP_START, 0, 0, 0);
    for (int i = 0; i < 70; i++) send(OP_STEP, 0, 0, 0);
    settle();

    // 2x2 loop north of the entrance: right turns drive the count to -127
    set_maze(2, 0, 15, 15, 3, 2);
    send(OP_VWALL, 2, 1, 1);
    send(OP_HWALL, 2, 1, 1);
    send(OP_HWALL, 2, 0, 0);
    send(OP_VWALL, 0, 1, 0);
    send(OP_VWALL, 1, 1, 0);
    send(OP_HWALL, 1, 0, 0);
    send(OP_HWALL, 1, 1, 0);
    send(OP_START, 0, 0, 0);
    no_idle = 1;                                // back-to-back stretch
    for (int i = 0; i < 140; i++) send(OP_STEP, 0, 0, 0);
    no_idle = 0;
    settle();

    // goal next to the entrance, then random walking on a small maze
    set_maze(0, 0, 0, 1, 6, 5);
    send(OP_VWALL, 0, 1, 0);
    send(OP_START, 0, 0, 0);
    send(OP_STEP, 0, 0, 0);
    send(OP_STEP, 0, 0, 0);
    random_walk(20);
    settle();

    // full size, entrance in the far corner, goal at the origin
    set_maze(15, 15, 0, 0, 16, 16);
    random_walk(25);
    settle();

    // single column maze
    set_maze(0, 0, 9, 0, 16, 1);
    random_walk(10);
    settle();

    // reset-like settings with random placement
    set_maze($urandom_range(0, 7), $urandom_range(0, 7), 4, 1, 16, 16);
    random_walk(15);
    settle();

    $display("covered %0d requests, %0d results, %0d at goal", n_items, n_results, n_goal);
    $display("turn count reached +limit %0d times, -limit %0d times", n_sat_pos, n_sat_neg);
    if (errors == 0 && pending_q.size() == 0) begin
      $display("pledge_maze_walker test passed");
    end else begin
      $display("pledge_maze_walker test failed");
    end
    $finish;
  end

endmodule
